@@ rtl/bsp_pkg.sv @@
// Shared types, codes and constants of the bank switch page table.
`default_nettype none

package bsp_pkg;

    localparam int CPU_PAGES     = 8;
    localparam int PPU_PAGES     = 12;
    localparam int CHR_RAM_BANKS = 32;

    localparam int IN_W  = 24;
    localparam int OUT_W = 24;
    localparam int CFG_W = 12;

    // Divider geometry: the largest dividend is a 12-bit bank times eight.
    localparam int DVD_W = 15;
    localparam int DIV_W = 12;
    localparam int REM_W = 11;

    localparam logic [DIV_W-1:0] PRG_COUNT_MAX = 12'd512;
    localparam logic [DIV_W-1:0] CHR_COUNT_MAX = 12'd2048;
    localparam logic [4:0]       NT_FIRST_PAGE = 5'd8;

    // Configuration register indexes.
    localparam logic CFG_PRG_COUNT = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    // Input actions.
    localparam logic [3:0] ACT_PRG8     = 4'd0;
    localparam logic [3:0] ACT_PRG16    = 4'd1;
    localparam logic [3:0] ACT_PRG32    = 4'd2;
    localparam logic [3:0] ACT_CHR1     = 4'd3;
    localparam logic [3:0] ACT_CHR2     = 4'd4;
    localparam logic [3:0] ACT_CHR4     = 4'd5;
    localparam logic [3:0] ACT_CHR8     = 4'd6;
    localparam logic [3:0] ACT_RAM1     = 4'd7;
    localparam logic [3:0] ACT_RAM2     = 4'd8;
    localparam logic [3:0] ACT_RAM4     = 4'd9;
    localparam logic [3:0] ACT_RAM8     = 4'd10;
    localparam logic [3:0] ACT_NT       = 4'd11;
    localparam logic [3:0] ACT_MIRROR   = 4'd12;
    localparam logic [3:0] ACT_READ_CPU = 4'd13;
    localparam logic [3:0] ACT_READ_PPU = 4'd14;

    // Region codes.
    localparam logic [2:0] RG_PRG_ROM  = 3'd0;
    localparam logic [2:0] RG_INT_RAM  = 3'd1;
    localparam logic [2:0] RG_WORK_RAM = 3'd2;
    localparam logic [2:0] RG_DUMMY    = 3'd3;
    localparam logic [2:0] RG_CHR_ROM  = 3'd4;
    localparam logic [2:0] RG_CHR_RAM  = 3'd5;
    localparam logic [2:0] RG_NT_RAM   = 3'd6;

    // Mirroring modes.
    localparam logic [2:0] MIR_HORIZ = 3'd0;
    localparam logic [2:0] MIR_VERT  = 3'd1;
    localparam logic [2:0] MIR_LOW   = 3'd2;
    localparam logic [2:0] MIR_HIGH  = 3'd3;
    localparam logic [2:0] MIR_FOUR  = 3'd4;

    typedef enum logic [2:0] {
        MODE_PRG,
        MODE_CHR,
        MODE_RAM,
        MODE_NT,
        MODE_MIRROR,
        MODE_READ_CPU,
        MODE_READ_PPU,
        MODE_NOP
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_DIV      = 5'b00100,
        S_WRITE    = 5'b01000,
        S_READ     = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic walk_init;
        logic write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_mod;
        logic is_read;
        logic is_nop;
        logic div_last;
        logic walk_last;
        logic read_ok;
        logic out_free;
    } t_status;

    // Nametable bank of page 8 + idx for a mirroring mode.
    function automatic logic [1:0] mirror_bank(input logic [2:0] mode,
                                               input logic [1:0] idx);
        logic [1:0] res;
        case (mode)
            MIR_HORIZ: res = {1'b0, idx[1]};
            MIR_VERT:  res = {1'b0, idx[0]};
            MIR_LOW:   res = 2'd0;
            MIR_HIGH:  res = 2'd1;
            MIR_FOUR:  res = idx;
            default:   res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bsp_ctrl.sv @@
// Sequencer of the bank switch page table: accepts words and steps the datapath.
`default_nettype none

module bsp_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  bsp_pkg::t_status i_status,
    output bsp_pkg::t_cmd    o_cmd
);

    bsp_pkg::t_state r_state;
    bsp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            bsp_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bsp_pkg::S_DISPATCH;
                end
            end
            bsp_pkg::S_DISPATCH: begin
                if (i_status.is_nop) begin
                    n_state = bsp_pkg::S_IDLE;
                end else if (i_status.is_read) begin
                    n_state = bsp_pkg::S_READ;
                end else if (i_status.need_mod) begin
                    n_state = bsp_pkg::S_DIV;
                end else begin
                    n_state = bsp_pkg::S_WRITE;
                end
            end
            bsp_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = bsp_pkg::S_WRITE;
                end
            end
            bsp_pkg::S_WRITE: begin
                o_cmd.write = 1'b1;
                if (i_status.walk_last) begin
                    n_state = bsp_pkg::S_IDLE;
                end
            end
            bsp_pkg::S_READ: begin
                if (!i_status.read_ok) begin
                    n_state = bsp_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/bsp_datapath.sv @@
// Datapath of the bank switch page table: page tables, bank divider and output register.
`default_nettype none

module bsp_datapath (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_index,
    input  wire  [bsp_pkg::CFG_W-1:0]  i_cfg_data,
    // fields from bit 0: action[3:0], page[7:4], bank_number[19:8], zero pad
    input  wire  [bsp_pkg::IN_W-1:0]   i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    // fields from bit 0: region[2:0], mapped_bank[13:3], chr_ram_used[21:14], zero pad
    output logic [bsp_pkg::OUT_W-1:0]  o_out_data,
    input  bsp_pkg::t_cmd              i_cmd,
    output bsp_pkg::t_status           o_status
);

    localparam int CPU_IDX_W = $clog2(bsp_pkg::CPU_PAGES);
    localparam int PPU_IDX_W = $clog2(bsp_pkg::PPU_PAGES);
    localparam int GRP_N     = bsp_pkg::CHR_RAM_BANKS / 4;

    // Configuration registers.
    logic [9:0]  r_prg_count;
    logic [11:0] r_chr_count;

    // Page tables.
    logic [2:0]  r_cpu_region [bsp_pkg::CPU_PAGES];
    logic [8:0]  r_cpu_bank   [bsp_pkg::CPU_PAGES];
    logic [2:0]  r_ppu_region [bsp_pkg::PPU_PAGES];
    logic [10:0] r_ppu_bank   [bsp_pkg::PPU_PAGES];
    logic [GRP_N-1:0] r_used;

    // Item being worked on.
    bsp_pkg::t_mode             r_mode;
    logic [4:0]                 r_page;
    logic [3:0]                 r_cnt;
    logic [1:0]                 r_idx;
    logic [bsp_pkg::REM_W-1:0]  r_val;
    logic [bsp_pkg::DIV_W-1:0]  r_div;
    logic [bsp_pkg::DVD_W-1:0]  r_dvd;
    logic [bsp_pkg::REM_W-1:0]  r_rem;
    logic [3:0]                 r_step;

    logic                       r_out_valid;
    logic [bsp_pkg::OUT_W-1:0]  r_out_data;

    // Decode of the incoming word.
    logic [3:0]  in_action;
    logic [3:0]  in_page;
    logic [11:0] in_bank;
    bsp_pkg::t_mode            d_mode;
    logic [4:0]                d_page;
    logic [3:0]                d_cnt;
    logic [1:0]                d_shift;
    logic [bsp_pkg::DVD_W-1:0] d_dvd;
    logic [bsp_pkg::REM_W-1:0] d_val;
    logic [bsp_pkg::DIV_W-1:0] eff_prg;
    logic [bsp_pkg::DIV_W-1:0] eff_chr;

    assign in_action = i_in_data[3:0];
    assign in_page   = i_in_data[7:4];
    assign in_bank   = i_in_data[19:8];

    always_comb begin
        if (r_prg_count == 10'd0) begin
            eff_prg = 12'd1;
        end else if ({2'b00, r_prg_count} > bsp_pkg::PRG_COUNT_MAX) begin
            eff_prg = bsp_pkg::PRG_COUNT_MAX;
        end else begin
            eff_prg = {2'b00, r_prg_count};
        end
        if (r_chr_count == 12'd0) begin
            eff_chr = 12'd1;
        end else if (r_chr_count > bsp_pkg::CHR_COUNT_MAX) begin
            eff_chr = bsp_pkg::CHR_COUNT_MAX;
        end else begin
            eff_chr = r_chr_count;
        end
    end

    always_comb begin
        d_mode  = bsp_pkg::MODE_NOP;
        d_page  = {1'b0, in_page};
        d_cnt   = 4'd1;
        d_shift = 2'd0;
        unique case (in_action)
            bsp_pkg::ACT_PRG8: begin
                d_mode = bsp_pkg::MODE_PRG;
            end
            bsp_pkg::ACT_PRG16: begin
                d_mode  = bsp_pkg::MODE_PRG;
                d_cnt   = 4'd2;
                d_shift = 2'd1;
            end
            bsp_pkg::ACT_PRG32: begin
                d_mode  = bsp_pkg::MODE_PRG;
                d_page  = 5'd4;
                d_cnt   = 4'd4;
                d_shift = 2'd2;
            end
            bsp_pkg::ACT_CHR1, bsp_pkg::ACT_RAM1: begin
                d_mode = (in_action == bsp_pkg::ACT_CHR1) ? bsp_pkg::MODE_CHR
                                                          : bsp_pkg::MODE_RAM;
            end
            bsp_pkg::ACT_CHR2, bsp_pkg::ACT_RAM2: begin
                d_mode  = (in_action == bsp_pkg::ACT_CHR2) ? bsp_pkg::MODE_CHR
                                                           : bsp_pkg::MODE_RAM;
                d_cnt   = 4'd2;
                d_shift = 2'd1;
            end
            bsp_pkg::ACT_CHR4, bsp_pkg::ACT_RAM4: begin
                d_mode  = (in_action == bsp_pkg::ACT_CHR4) ? bsp_pkg::MODE_CHR
                                                           : bsp_pkg::MODE_RAM;
                d_cnt   = 4'd4;
                d_shift = 2'd2;
            end
            bsp_pkg::ACT_CHR8, bsp_pkg::ACT_RAM8: begin
                d_mode  = (in_action == bsp_pkg::ACT_CHR8) ? bsp_pkg::MODE_CHR
                                                           : bsp_pkg::MODE_RAM;
                d_page  = 5'd0;
                d_cnt   = 4'd8;
                d_shift = 2'd3;
            end
            bsp_pkg::ACT_NT: begin
                d_mode = bsp_pkg::MODE_NT;
            end
            bsp_pkg::ACT_MIRROR: begin
                // Unknown mirroring modes leave the table untouched.
                if (in_bank <= 12'd4) begin
                    d_mode = bsp_pkg::MODE_MIRROR;
                    d_page = bsp_pkg::NT_FIRST_PAGE;
                    d_cnt  = 4'd4;
                end
            end
            bsp_pkg::ACT_READ_CPU: begin
                d_mode = bsp_pkg::MODE_READ_CPU;
            end
            bsp_pkg::ACT_READ_PPU: begin
                d_mode = bsp_pkg::MODE_READ_PPU;
            end
            default: begin
                d_mode = bsp_pkg::MODE_NOP;
            end
        endcase
        d_dvd = bsp_pkg::DVD_W'(in_bank) << d_shift;
        case (d_mode)
            bsp_pkg::MODE_RAM:    d_val = {6'd0, d_dvd[4:0]};
            bsp_pkg::MODE_NT:     d_val = {9'd0, in_bank[1:0]};
            bsp_pkg::MODE_MIRROR: d_val = {8'd0, in_bank[2:0]};
            default:              d_val = '0;
        endcase
    end

    // One restoring division step per cycle on the stored dividend.
    logic [bsp_pkg::DIV_W-1:0] rem_shift;
    logic [bsp_pkg::REM_W-1:0] n_rem;

    always_comb begin
        rem_shift = {r_rem, r_dvd[bsp_pkg::DVD_W-1]};
        if (rem_shift >= r_div) begin
            n_rem = bsp_pkg::REM_W'(rem_shift - r_div);
        end else begin
            n_rem = bsp_pkg::REM_W'(rem_shift);
        end
    end

    // Walk over the pages of one command.
    logic                      is_mod_mode;
    logic                      to_cpu;
    logic                      page_ok;
    logic [bsp_pkg::DIV_W-1:0] val_inc;
    logic [bsp_pkg::REM_W-1:0] n_val;
    logic [2:0]                wr_region;
    logic [10:0]               wr_bank;

    assign is_mod_mode = (r_mode == bsp_pkg::MODE_PRG) || (r_mode == bsp_pkg::MODE_CHR);
    assign to_cpu      = (r_mode == bsp_pkg::MODE_PRG) || (r_mode == bsp_pkg::MODE_READ_CPU);
    assign page_ok     = to_cpu ? (r_page < 5'(bsp_pkg::CPU_PAGES))
                                : (r_page < 5'(bsp_pkg::PPU_PAGES));
    assign val_inc     = {1'b0, r_val} + 12'd1;

    always_comb begin
        // Consecutive banks wrap at the bank count without a second division.
        if (r_mode == bsp_pkg::MODE_MIRROR) begin
            n_val = r_val;
        end else if (is_mod_mode && (val_inc == r_div)) begin
            n_val = '0;
        end else begin
            n_val = bsp_pkg::REM_W'(val_inc);
        end
        case (r_mode)
            bsp_pkg::MODE_CHR: begin
                wr_region = bsp_pkg::RG_CHR_ROM;
                wr_bank   = r_val;
            end
            bsp_pkg::MODE_RAM: begin
                wr_region = bsp_pkg::RG_CHR_RAM;
                wr_bank   = r_val;
            end
            bsp_pkg::MODE_NT: begin
                wr_region = bsp_pkg::RG_NT_RAM;
                wr_bank   = r_val;
            end
            bsp_pkg::MODE_MIRROR: begin
                wr_region = bsp_pkg::RG_NT_RAM;
                wr_bank   = {9'd0, bsp_pkg::mirror_bank(r_val[2:0], r_idx)};
            end
            default: begin
                wr_region = bsp_pkg::RG_PRG_ROM;
                wr_bank   = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count <= 10'd1;
            r_chr_count <= 12'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == bsp_pkg::CFG_PRG_COUNT) begin
                r_prg_count <= i_cfg_data[9:0];
            end
            if (i_cfg_index == bsp_pkg::CFG_CHR_COUNT) begin
                r_chr_count <= i_cfg_data[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bsp_pkg::MODE_NOP;
        end else if (i_cmd.load) begin
            r_mode <= d_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= d_page;
            r_cnt  <= d_cnt;
            r_idx  <= 2'd0;
            r_val  <= d_val;
            r_div  <= (d_mode == bsp_pkg::MODE_PRG) ? eff_prg : eff_chr;
            r_dvd  <= d_dvd;
            r_rem  <= '0;
            r_step <= 4'(bsp_pkg::DVD_W);
        end else begin
            if (i_cmd.div_step) begin
                r_dvd  <= r_dvd << 1;
                r_rem  <= n_rem;
                r_step <= r_step - 4'd1;
            end
            if (i_cmd.walk_init) begin
                r_val <= n_rem;
            end
            if (i_cmd.write) begin
                r_page <= r_page + 5'd1;
                r_cnt  <= r_cnt - 4'd1;
                r_idx  <= r_idx + 2'd1;
                r_val  <= n_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bsp_pkg::CPU_PAGES; i++) begin
                r_cpu_region[i] <= bsp_pkg::RG_PRG_ROM;
                r_cpu_bank[i]   <= '0;
            end
            r_cpu_region[0] <= bsp_pkg::RG_INT_RAM;
            r_cpu_region[1] <= bsp_pkg::RG_DUMMY;
            r_cpu_region[2] <= bsp_pkg::RG_DUMMY;
            r_cpu_region[3] <= bsp_pkg::RG_WORK_RAM;
            for (int i = 0; i < bsp_pkg::PPU_PAGES; i++) begin
                r_ppu_region[i] <= '0;
                r_ppu_bank[i]   <= '0;
            end
            r_used <= '0;
        end else if (i_cmd.write && page_ok) begin
            if (to_cpu) begin
                r_cpu_region[r_page[CPU_IDX_W-1:0]] <= wr_region;
                r_cpu_bank[r_page[CPU_IDX_W-1:0]]   <= wr_bank[8:0];
            end else begin
                r_ppu_region[r_page[PPU_IDX_W-1:0]] <= wr_region;
                r_ppu_bank[r_page[PPU_IDX_W-1:0]]   <= wr_bank;
                if (r_mode == bsp_pkg::MODE_RAM) begin
                    r_used[r_val[4:2]] <= 1'b1;
                end
            end
        end
    end

    // Output register: a read may load it in the cycle the previous word leaves.
    logic [2:0]  rd_region;
    logic [10:0] rd_bank;

    always_comb begin
        if (to_cpu) begin
            rd_region = r_cpu_region[r_page[CPU_IDX_W-1:0]];
            rd_bank   = {2'b00, r_cpu_bank[r_page[CPU_IDX_W-1:0]]};
        end else begin
            rd_region = r_ppu_region[r_page[PPU_IDX_W-1:0]];
            rd_bank   = r_ppu_bank[r_page[PPU_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, r_used, rd_bank, rd_region};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.need_mod  = is_mod_mode;
    assign o_status.is_read   = (r_mode == bsp_pkg::MODE_READ_CPU) ||
                                (r_mode == bsp_pkg::MODE_READ_PPU);
    assign o_status.is_nop    = (r_mode == bsp_pkg::MODE_NOP);
    assign o_status.div_last  = (r_step == 4'd1);
    assign o_status.walk_last = (r_cnt == 4'd1);
    assign o_status.read_ok   = page_ok;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

@@ rtl/bank_switch_page_table.sv @@
// Top level of the bank switch page table: sequencer plus datapath.
//
//  port group     dir   payload                                     accepted when
//  s_axis_*       in    action, page, bank_number                   tvalid && tready
//  m_axis_*       out   region, mapped_bank, chr_ram_used           tvalid && tready
//  i_cfg_*        in    prg_bank_count (0), chr_bank_count (1)      i_cfg_we
//
// One word is worked on at a time; tready is high only while the sequencer is idle.
// Program and character ROM sets pass through dispatch, a 15-step restoring divider
// that reduces the first bank, and a write pass of 1 to 8 pages, one per cycle;
// later banks wrap by compare. Character RAM, nametable and mirroring sets go
// from dispatch straight to the write pass; reads of a page in the table wait
// for the output register to empty; other words return to idle after dispatch.
// Synchronous reset restores the page tables at once; no clearing pass is needed.
// A stalled output does not block writes; only a following read waits for it.
`default_nettype none

module bank_switch_page_table (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_index,
    input  wire  [bsp_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // fields from bit 0: action[3:0], page[7:4], bank_number[19:8], zero pad
    input  wire  [bsp_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // fields from bit 0: region[2:0], mapped_bank[13:3], chr_ram_used[21:14], zero pad
    output logic [bsp_pkg::OUT_W-1:0]  m_axis_tdata
);

    bsp_pkg::t_cmd    cmd;
    bsp_pkg::t_status status;

    bsp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    bsp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

@@ rtl/bsp_checker.sv @@
// Port-level checks of the bank switch page table and their bind to the top level.
`default_nettype none

module bsp_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       s_axis_tvalid,
    input wire                       s_axis_tready,
    input wire [bsp_pkg::OUT_W-1:0]  m_axis_tdata,
    input wire                       m_axis_tvalid,
    input wire                       m_axis_tready
);

    // A stalled output word holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // The sequencer leaves idle on every accepted word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready held high after an accept");

    // Internal, work and dummy regions only come from reset and keep bank zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == bsp_pkg::RG_INT_RAM ||
                          m_axis_tdata[2:0] == bsp_pkg::RG_WORK_RAM ||
                          m_axis_tdata[2:0] == bsp_pkg::RG_DUMMY)
        |-> m_axis_tdata[13:3] == 11'd0)
        else $error("reset-only region with nonzero bank");

    // Nametable banks stay below four and character RAM banks below thirty-two.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[2:0] != bsp_pkg::RG_NT_RAM || m_axis_tdata[13:5] == 9'd0) &&
            (m_axis_tdata[2:0] != bsp_pkg::RG_CHR_RAM || m_axis_tdata[13:8] == 6'd0))
        else $error("RAM bank out of range");

endmodule

bind bank_switch_page_table bsp_checker u_bsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

@@ tb/sv/tb_bank_switch_page_table.sv @@
// Self-checking testbench for the bank switch page table: stream driver, monitor and page map predictor.
`default_nettype none

module tb_bank_switch_page_table;
    import bsp_pkg::*;

    localparam logic [3:0] ACT_UNUSED   = 4'd15;
    localparam int         MAX_GAP      = 17;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         LONG_HOLD    = 400;
    localparam int         PHASE_ITEMS  = 250;
    localparam int         MAX_REPORTS  = 10;

    typedef struct packed {
        logic [11:0] bank;
        logic [3:0]  page;
        logic [3:0]  action;
    } bank_cmd_t;

    typedef struct packed {
        logic [7:0]  used;
        logic [10:0] bank;
        logic [2:0]  region;
    } page_entry_t;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic             i_cfg_index   = 1'b0;
    logic [CFG_W-1:0] i_cfg_data    = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // fields from bit 0: action[3:0], page[7:4], bank_number[19:8], zero pad
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // fields from bit 0: region[2:0], mapped_bank[13:3], chr_ram_used[21:14], zero pad
    logic [OUT_W-1:0] m_axis_tdata;

    bank_switch_page_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Our own copy of the bank map and the two count registers.
    logic [9:0]  prg_count_reg;
    logic [11:0] chr_count_reg;
    logic [2:0]  cpu_region [CPU_PAGES];
    logic [10:0] cpu_bank   [CPU_PAGES];
    logic [2:0]  ppu_region [PPU_PAGES];
    logic [10:0] ppu_bank   [PPU_PAGES];
    logic [7:0]  chr_ram_groups;

    bank_cmd_t   cmd_pending[$];
    page_entry_t entries_due[$];

    int          n_accepted = 0;
    int          n_mismatch = 0;
    int          tx_wait;
    int          rx_wait;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int          hold_left;
    int          hold_at;
    page_entry_t got_entry;
    page_entry_t want_entry;

    function automatic int clamp_count(int cnt, int max_cnt);
        if (cnt == 0) return 1;
        if (cnt > max_cnt) return max_cnt;
        return cnt;
    endfunction

    function automatic void map_prg(int page, int bank);
        if (page >= CPU_PAGES) return;
        cpu_region[page] = RG_PRG_ROM;
        cpu_bank[page]   = 11'(bank % clamp_count(prg_count_reg, PRG_COUNT_MAX));
    endfunction

    function automatic void map_chr_rom(int page, int bank);
        if (page >= PPU_PAGES) return;
        ppu_region[page] = RG_CHR_ROM;
        ppu_bank[page]   = 11'(bank % clamp_count(chr_count_reg, CHR_COUNT_MAX));
    endfunction

    function automatic void map_chr_ram(int page, int bank);
        int low_bank;
        low_bank = bank & (CHR_RAM_BANKS - 1);
        if (page >= PPU_PAGES) return;
        ppu_region[page] = RG_CHR_RAM;
        ppu_bank[page]   = 11'(low_bank);
        chr_ram_groups[(low_bank >> 2) & 7] = 1'b1;
    endfunction

    function automatic void map_nt(int page, int bank);
        if (page >= PPU_PAGES) return;
        ppu_region[page] = RG_NT_RAM;
        ppu_bank[page]   = 11'(bank & 3);
    endfunction

    // Nametable bank that a mirroring mode puts on the idx-th nametable page.
    function automatic int nt_bank_for(int mode, int idx);
        case (mode)
            MIR_HORIZ: return idx >> 1;
            MIR_VERT:  return idx & 1;
            MIR_LOW:   return 0;
            MIR_HIGH:  return 1;
            default:   return idx;
        endcase
    endfunction

    function automatic void reset_page_map();
        int i;
        prg_count_reg  = 10'd1;
        chr_count_reg  = 12'd1;
        chr_ram_groups = '0;
        for (i = 0; i < CPU_PAGES; i++) begin
            cpu_region[i] = RG_PRG_ROM;
            cpu_bank[i]   = '0;
        end
        for (i = 0; i < PPU_PAGES; i++) begin
            ppu_region[i] = RG_PRG_ROM;
            ppu_bank[i]   = '0;
        end
        cpu_region[0] = RG_INT_RAM;
        cpu_region[1] = RG_DUMMY;
        cpu_region[2] = RG_DUMMY;
        cpu_region[3] = RG_WORK_RAM;
    endfunction

    // Updates the bank map for one accepted word and queues the entry a read returns.
    function automatic void apply_cmd(bank_cmd_t c);
        int          pg;
        int          bk;
        int          i;
        page_entry_t e;
        pg = c.page;
        bk = c.bank;
        case (c.action)
            ACT_PRG8:  map_prg(pg, bk);
            ACT_PRG16: for (i = 0; i < 2; i++) map_prg(pg + i, bk * 2 + i);
            ACT_PRG32: for (i = 0; i < 4; i++) map_prg(CPU_PAGES / 2 + i, bk * 4 + i);
            ACT_CHR1:  map_chr_rom(pg, bk);
            ACT_CHR2:  for (i = 0; i < 2; i++) map_chr_rom(pg + i, bk * 2 + i);
            ACT_CHR4:  for (i = 0; i < 4; i++) map_chr_rom(pg + i, bk * 4 + i);
            ACT_CHR8:  for (i = 0; i < 8; i++) map_chr_rom(i, bk * 8 + i);
            ACT_RAM1:  map_chr_ram(pg, bk);
            ACT_RAM2:  for (i = 0; i < 2; i++) map_chr_ram(pg + i, bk * 2 + i);
            ACT_RAM4:  for (i = 0; i < 4; i++) map_chr_ram(pg + i, bk * 4 + i);
            ACT_RAM8:  for (i = 0; i < 8; i++) map_chr_ram(i, bk * 8 + i);
            ACT_NT:    map_nt(pg, bk);
            ACT_MIRROR: begin
                if (bk <= MIR_FOUR)
                    for (i = 0; i < 4; i++) map_nt(NT_FIRST_PAGE + i, nt_bank_for(bk, i));
            end
            ACT_READ_CPU: begin
                if (pg < CPU_PAGES) begin
                    e.region = cpu_region[pg];
                    e.bank   = cpu_bank[pg];
                    e.used   = chr_ram_groups;
                    entries_due.push_back(e);
                end
            end
            ACT_READ_PPU: begin
                if (pg < PPU_PAGES) begin
                    e.region = ppu_region[pg];
                    e.bank   = ppu_bank[pg];
                    e.used   = chr_ram_groups;
                    entries_due.push_back(e);
                end
            end
            default: ;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: presents queued words and draws an idle gap after each accept.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_cmd(bank_cmd_t'(s_axis_tdata[19:0]));
                n_accepted <= n_accepted + 1;
                if ($urandom_range(0, 29) == 0) tx_quiet = !tx_quiet;
                tx_wait = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_wait == 0 && cmd_pending.size() > 0) begin
                    s_axis_tdata  <= {4'b0, cmd_pending.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (tx_wait > 0) tx_wait--;
                end
            end
        end
    end

    // Receiver: checks each word against the oldest predicted entry.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_entry = page_entry_t'(m_axis_tdata[21:0]);
                if (entries_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("unexpected word: region %0d bank %0d used %02h",
                                 got_entry.region, got_entry.bank, got_entry.used);
                end else begin
                    want_entry = entries_due.pop_front();
                    if (got_entry.region !== want_entry.region ||
                        got_entry.bank !== want_entry.bank ||
                        got_entry.used !== want_entry.used) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS)
                            $display("mismatch: expected region %0d bank %0d used %02h, %s",
                                     want_entry.region, want_entry.bank, want_entry.used,
                                     $sformatf("got region %0d bank %0d used %02h",
                                               got_entry.region, got_entry.bank,
                                               got_entry.used));
                    end
                end
                if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
                rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // Long receiver stalls so that the output register fills and input backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_at   <= 200;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (n_accepted >= hold_at) begin
            hold_left <= LONG_HOLD;
            hold_at   <= hold_at + 700;
        end
    end

    task automatic queue_cmd(input logic [3:0] action, input int page, input int bank);
        bank_cmd_t c;
        c.action = action;
        c.page   = 4'(page);
        c.bank   = 12'(bank);
        cmd_pending.push_back(c);
    endtask

    // Waits until every word is sent and every entry returned, then lets the block drain.
    task automatic settle();
        @(negedge i_clk);
        while (cmd_pending.size() != 0 || s_axis_tvalid || entries_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(input logic index, input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= CFG_W'(value);
        if (index == CFG_PRG_COUNT) prg_count_reg = 10'(value);
        else chr_count_reg = 12'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_random(input int n);
        int        k;
        int        r;
        logic [3:0] act;
        int        pg;
        int        bk;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) act = $urandom_range(0, 1) ? ACT_READ_CPU : ACT_READ_PPU;
            else if (r < 90) act = 4'($urandom_range(ACT_PRG8, ACT_NT));
            else if (r < 97) act = ACT_MIRROR;
            else act = ACT_UNUSED;
            if ($urandom_range(0, 9) == 0)
                pg = $urandom_range(0, 15);
            else if (act == ACT_READ_CPU || act <= ACT_PRG32)
                pg = $urandom_range(0, CPU_PAGES - 1);
            else
                pg = $urandom_range(0, PPU_PAGES - 1);
            r = $urandom_range(0, 7);
            if (act == ACT_MIRROR)
                bk = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(MIR_HORIZ, MIR_FOUR);
            else if (r == 0) bk = 4095;
            else if (r == 1) bk = 0;
            else if (r == 2) bk = $urandom_range(0, 15);
            else bk = $urandom_range(0, 4095);
            queue_cmd(act, pg, bk);
        end
    endtask

    initial begin
        reset_page_map();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset contents, edge pages, pages past the table and every action.
        queue_cmd(ACT_READ_CPU, 0, 0);
        queue_cmd(ACT_READ_CPU, 3, 0);
        queue_cmd(ACT_READ_PPU, 0, 0);
        queue_cmd(ACT_PRG8, 7, 4095);
        queue_cmd(ACT_PRG16, 7, 4095);
        queue_cmd(ACT_PRG32, 15, 4095);
        queue_cmd(ACT_READ_CPU, 7, 0);
        queue_cmd(ACT_READ_CPU, 4, 0);
        queue_cmd(ACT_CHR1, 11, 4095);
        queue_cmd(ACT_CHR2, 11, 4095);
        queue_cmd(ACT_CHR4, 15, 4095);
        queue_cmd(ACT_CHR8, 0, 0);
        queue_cmd(ACT_READ_PPU, 11, 0);
        queue_cmd(ACT_RAM1, 0, 4095);
        queue_cmd(ACT_RAM2, 10, 31);
        queue_cmd(ACT_RAM4, 2, 7);
        queue_cmd(ACT_RAM8, 0, 4095);
        queue_cmd(ACT_READ_PPU, 10, 0);
        queue_cmd(ACT_NT, 11, 4095);
        queue_cmd(ACT_MIRROR, 0, MIR_FOUR);
        queue_cmd(ACT_MIRROR, 0, 4095);
        queue_cmd(ACT_READ_PPU, 9, 0);
        queue_cmd(ACT_READ_CPU, 8, 0);
        queue_cmd(ACT_READ_PPU, 15, 0);
        queue_cmd(ACT_UNUSED, 15, 4095);
        settle();

        // A zero count acts as one.
        write_count(CFG_PRG_COUNT, 0);
        write_count(CFG_CHR_COUNT, 0);
        queue_random(PHASE_ITEMS);
        settle();

        write_count(CFG_PRG_COUNT, PRG_COUNT_MAX);
        write_count(CFG_CHR_COUNT, CHR_COUNT_MAX);
        queue_random(PHASE_ITEMS);
        settle();

        // Counts above the maximum are clamped.
        write_count(CFG_PRG_COUNT, 1023);
        write_count(CFG_CHR_COUNT, 4095);
        queue_random(PHASE_ITEMS);
        settle();

        write_count(CFG_PRG_COUNT, 3);
        write_count(CFG_CHR_COUNT, 5);
        queue_random(PHASE_ITEMS);
        settle();

        write_count(CFG_PRG_COUNT, PRG_COUNT_MAX + 1);
        write_count(CFG_CHR_COUNT, CHR_COUNT_MAX + 1);
        queue_random(PHASE_ITEMS);
        settle();

        write_count(CFG_PRG_COUNT, $urandom_range(1, PRG_COUNT_MAX));
        write_count(CFG_CHR_COUNT, $urandom_range(1, CHR_COUNT_MAX));
        queue_random(PHASE_ITEMS);
        settle();

        if (n_mismatch == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
